FILE: src/sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// checked outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/spq_pkg.sv
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CapacityDef = 16;
  localparam int ValueW      = 32;
  localparam int OpW         = 2;
  localparam int CountW      = 5;
  localparam int StatusW     = 2;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpDelete = 2'd1;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueW-1:0] min_value;
    logic [CountW-1:0]        count;
    logic [StatusW-1:0]       status;
  } res_t;

endpackage

FILE: src/spq_if.sv
// valid/ready channel interfaces of the sorted priority queue
`timescale 1ns / 1ps

interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::OpW-1:0]          opcode;
  logic signed [spq_pkg::ValueW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [spq_pkg::ValueW-1:0] min_value;
  logic [spq_pkg::CountW-1:0]        count;
  logic [spq_pkg::StatusW-1:0]       status;

  modport source (output valid, output min_value, output count, output status, input ready);
  modport sink   (input valid, input min_value, input count, input status, output ready);
endinterface

FILE: src/spq_cell.sv
// one storage cell of the sorted shift chain
`timescale 1ns / 1ps

module spq_cell (
  input  logic                              clk_i,
  input  spq_pkg::cmd_t                     cmd_i,
  input  logic                              occ_i,
  input  logic                              at_end_i,
  input  logic                              left_gt_i,
  input  logic signed [spq_pkg::ValueW-1:0] left_entry_i,
  input  logic signed [spq_pkg::ValueW-1:0] right_entry_i,
  output logic                              gt_o,
  output logic signed [spq_pkg::ValueW-1:0] entry_o,
  output logic signed [spq_pkg::ValueW-1:0] entry_d_o
);

  logic signed [spq_pkg::ValueW-1:0] entry_q;
  logic signed [spq_pkg::ValueW-1:0] entry_d;

  assign gt_o = occ_i && (cmd_i.value < entry_q);

  always_comb begin
    if (cmd_i.ins && (gt_o || at_end_i)) begin
      entry_d = left_gt_i ? left_entry_i : cmd_i.value;
    end else if (cmd_i.del) begin
      entry_d = right_entry_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

FILE: src/spq_chain.sv
// cell chain with fill count and result forming
`timescale 1ns / 1ps

`include "sorted_priority_queue_assert.svh"

module spq_chain #(
  parameter int Capacity = spq_pkg::CapacityDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic [spq_pkg::OpW-1:0]           opcode_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_i,
  output spq_pkg::res_t                     res_o
);

  localparam int FillW = $clog2(Capacity + 1);

  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] fill_d;
  logic             full;
  logic             empty;
  logic             is_ins;
  logic             ins_en;
  logic             del_en;
  spq_pkg::cmd_t    cmd;
  logic [31:0]      fill_ext;

  logic                              occ     [Capacity];
  logic                              at_end  [Capacity];
  logic                              gt      [Capacity];
  logic                              left_gt [Capacity];
  logic signed [spq_pkg::ValueW-1:0] ent     [Capacity];
  logic signed [spq_pkg::ValueW-1:0] ent_d   [Capacity];
  logic signed [spq_pkg::ValueW-1:0] left_e  [Capacity];
  logic signed [spq_pkg::ValueW-1:0] right_e [Capacity];

  assign full   = (fill_q == FillW'(Capacity));
  assign empty  = (fill_q == '0);
  assign is_ins = (opcode_i == spq_pkg::OpInsert);
  assign ins_en = acc_i && is_ins && !full;
  assign del_en = acc_i && (opcode_i == spq_pkg::OpDelete) && !empty;

  assign cmd.ins   = ins_en;
  assign cmd.del   = del_en;
  assign cmd.value = value_i;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign occ[i]    = (FillW'(i) < fill_q);
    assign at_end[i] = (FillW'(i) == fill_q);
    if (i == 0) begin : g_first
      assign left_gt[i] = 1'b0;
      assign left_e[i]  = '0;
    end else begin : g_mid
      assign left_gt[i] = gt[i-1];
      assign left_e[i]  = ent[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_e[i] = ent[i];
    end else begin : g_inner
      assign right_e[i] = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .at_end_i      (at_end[i]),
      .left_gt_i     (left_gt[i]),
      .left_entry_i  (left_e[i]),
      .right_entry_i (right_e[i]),
      .gt_o          (gt[i]),
      .entry_o       (ent[i]),
      .entry_d_o     (ent_d[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ins_en) begin
      fill_d = fill_q + 1'b1;
    end else if (del_en) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign fill_ext = 32'(fill_d);

  always_comb begin
    res_o.min_value = (fill_d != '0) ? ent_d[0] : '0;
    res_o.count     = fill_ext[spq_pkg::CountW-1:0];
    if (is_ins && full) begin
      res_o.status = spq_pkg::StFull;
    end else if (!is_ins && empty) begin
      res_o.status = spq_pkg::StEmpty;
    end else begin
      res_o.status = spq_pkg::StOk;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_fill_bound, fill_q <= FillW'(Capacity), "fill count above capacity")
  `SPQ_ASSERT(a_ins_grow, ins_en |=> (fill_q == $past(fill_q) + 1'b1), "insert did not grow")
  `SPQ_ASSERT(a_del_shrink, del_en |=> (fill_q == $past(fill_q) - 1'b1), "delete did not shrink")
  `SPQ_ASSERT(a_head_sorted, (fill_q >= FillW'(2)) |-> (ent[0] <= ent[1]), "head out of order")

endmodule

FILE: src/spq_out_buf.sv
// two-beat output buffer between the chain and the result channel
`timescale 1ns / 1ps

module spq_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  spq_pkg::res_t   res_i,
  output logic            ready_o,
  spq_out_if.source       out_o
);

  spq_pkg::res_t out_q;
  spq_pkg::res_t skid_q;
  logic          ov_q;
  logic          sv_q;
  logic          to_out;
  logic          to_skid;
  logic          pop_skid;

  assign ready_o  = !sv_q;
  assign to_out   = we_i && (!ov_q || out_o.ready);
  assign to_skid  = we_i && ov_q && !out_o.ready;
  assign pop_skid = !we_i && ov_q && out_o.ready && sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (to_out) begin
        ov_q <= 1'b1;
      end else if (to_skid) begin
        sv_q <= 1'b1;
      end else if (ov_q && out_o.ready) begin
        ov_q <= sv_q;
        sv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (to_out) begin
      out_q <= res_i;
    end else if (pop_skid) begin
      out_q <= skid_q;
    end
    if (to_skid) begin
      skid_q <= res_i;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.min_value = out_q.min_value;
  assign out_o.count     = out_q.count;
  assign out_o.status    = out_q.status;

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted min-priority queue built as a chain of compare-and-shift cells. Each
// cell holds one entry; on an insert every occupied cell compares the new value
// with its entry at once, the cell at the insert point takes the new value and
// the cells above it take their left neighbor's entry; on a delete every cell
// takes its right neighbor's. One item is taken per cycle; its result (minimum,
// count, status) is registered in the two-beat output buffer, and all cells
// compare and shift together. Input keeps flowing while one result waits and
// stalls only when both buffer slots are full.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int Capacity = spq_pkg::CapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  spq_pkg::res_t res;
  logic          buf_ready;
  logic          acc;

  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid && buf_ready;

  spq_chain #(
    .Capacity (Capacity)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .opcode_i (in_i.opcode),
    .value_i  (in_i.value),
    .res_o    (res)
  );

  spq_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (acc),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule
